// ===== rtl/core/ppss_pkg.sv =====
// ppss_pkg: shared types, constants and codes for the priority scheduler
// no dependencies
`timescale 1ns / 1ps
package ppss_pkg;
	localparam int SERVERS = 4;
	localparam int PRIORITIES = 2;
	localparam int SW = 3;
	localparam int PW = 4;
	localparam int QW = 6;
	localparam int CW = 32;
	// index widths for the server and per-priority arrays
	localparam int SIW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
	localparam int PIW = $clog2(PRIORITIES);

	localparam logic [1:0] OP_ARRIVE = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_CHECK  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [2:0] ACT_START   = 3'd0;
	localparam logic [2:0] ACT_ENQ     = 3'd1;
	localparam logic [2:0] ACT_REFUSE  = 3'd2;
	localparam logic [2:0] ACT_PUSH    = 3'd3;
	localparam logic [2:0] ACT_PREEMPT = 3'd4;
	localparam logic [2:0] ACT_IDLE    = 3'd5;
	localparam logic [2:0] ACT_COUNT   = 3'd6;

	localparam logic REG_QLIMIT = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECIDE, ST_CHECK, ST_EMIT
	} state_t;

	// input channel payload
	typedef struct packed {
		logic [1:0]    opcode;
		logic [PW-1:0] priority_req;
		logic [SW-1:0] server;
	} in_item_t;

	// output channel payload
	typedef struct packed {
		logic [2:0]    action;
		logic [PW-1:0] action_priority;
		logic [SW-1:0] action_server;
		logic [CW-1:0] arrival_count;
		logic [CW-1:0] refusal_count;
		logic          last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [PW-1:0] prio;
		logic [SW-1:0] srv;
		logic [CW-1:0] arr;
		logic [CW-1:0] refc;
		logic        last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture input item
		logic step;    // run one event step on the datapath
		logic chk_next;// advance check server index
		logic chk_init;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic [2:0] nres;   // results produced by this step (0..4)
		logic       chk_done;
	} stat_t;
endpackage

// ===== rtl/core/ppss_if.sv =====
// ppss_if: valid/ready channel carrying one payload
// depends on nothing
`timescale 1ns / 1ps
interface ppss_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/priority_pushout_server_scheduler_unit.sv =====
// priority_pushout_server_scheduler_unit: top level of the priority scheduler
// states: load in IDLE, step in DECIDE, CHECK, then one result a cycle in EMIT
// while out_ready is high; a check tick steps once per server scanned, and
// the scan stops once no later server can be preempted
// one item at a time: a new item is taken only in IDLE, after the last result,
// and output stalls hold the block
// async active-low reset clears queues, servers and counters, registers to 6 and 2
`timescale 1ns / 1ps
module priority_pushout_server_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [5:0]  cfg_data,
	ppss_if.sink        in_ch,
	ppss_if.source      out_ch
);
	ppss_pkg::cmd_t    cmd;
	ppss_pkg::stat_t   stat;
	ppss_pkg::result_t res [4];
	ppss_pkg::result_t od;

	// datapath holds all scheduler state and computes one event step per command
	ppss_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_op(in_ch.data.opcode), .in_prio(in_ch.data.priority_req),
		.in_srv(in_ch.data.server),
		.cmd(cmd), .stat(stat), .res(res)
	);

	// controller sequences transfers and steps
	ppss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .res(res), .out_data(od), .cmd(cmd)
	);

	assign out_ch.data.action = od.action;
	assign out_ch.data.action_priority = od.prio;
	assign out_ch.data.action_server = od.srv;
	assign out_ch.data.arrival_count = od.arr;
	assign out_ch.data.refusal_count = od.refc;
	assign out_ch.data.last = od.last;
endmodule

// ===== rtl/core/ppss_datapath.sv =====
// ppss_datapath: scheduler state, counters and per-step result generation
// depends on ppss_pkg
`timescale 1ns / 1ps
module ppss_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_idx,
	input  logic [5:0]          cfg_data,
	input  logic [1:0]          in_op,
	input  logic [3:0]          in_prio,
	input  logic [2:0]          in_srv,
	input  ppss_pkg::cmd_t      cmd,
	output ppss_pkg::stat_t     stat,
	output ppss_pkg::result_t   res [4]
);
	localparam int S = ppss_pkg::SERVERS;
	localparam int P = ppss_pkg::PRIORITIES;
	localparam int SIW = ppss_pkg::SIW;
	localparam int PIW = ppss_pkg::PIW;

	logic [5:0] qlimit_q, thresh_q;
	logic [5:0] queued_q [P];
	logic [3:0] srvp_q [S];
	logic [31:0] arr_q [P];
	logic [31:0] ref_q [P];
	logic [1:0] op_q;
	logic [3:0] prio_q;
	logic [2:0] srv_q;
	logic [2:0] ci_q;   // check server index
	logic       chk_ok_q; // threshold met when the check tick was taken

	logic [5:0] queued_d [P];
	logic [3:0] srvp_d [S];
	logic       arr_inc [P];
	logic       ref_inc [P];
	ppss_pkg::result_t r [4];
	logic [2:0] n;
	logic [8:0] total;
	logic       pok, found, qhit, later;
	logic [2:0] fs;
	logic [3:0] evp, qp;
	logic [PIW-1:0] pidx, eidx, qidx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlimit_q <= 6'd6;
			thresh_q <= 6'd2;
		end else if (cfg_we) begin
			if (cfg_idx == ppss_pkg::REG_QLIMIT) qlimit_q <= cfg_data;
			else thresh_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			prio_q <= in_prio;
			srv_q <= in_srv;
		end
	end

	// threshold is judged once per check tick, before any server is preempted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= '0;
			chk_ok_q <= 1'b0;
		end else if (cmd.chk_init) begin
			ci_q <= '0;
			chk_ok_q <= queued_q[0] >= thresh_q;
		end else if (cmd.chk_next) ci_q <= ci_q + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < P; i++) begin
				queued_q[i] <= '0; arr_q[i] <= '0; ref_q[i] <= '0;
			end
			for (int i = 0; i < S; i++) srvp_q[i] <= '0;
		end else if (cmd.step) begin
			for (int i = 0; i < P; i++) begin
				queued_q[i] <= queued_d[i];
				if (arr_inc[i] && arr_q[i] != '1) arr_q[i] <= arr_q[i] + 32'd1;
				if (ref_inc[i] && ref_q[i] != '1) ref_q[i] <= ref_q[i] + 32'd1;
			end
			for (int i = 0; i < S; i++) srvp_q[i] <= srvp_d[i];
		end
	end

	function automatic ppss_pkg::result_t mk(logic [2:0] a, logic [3:0] p, logic [2:0] s);
		ppss_pkg::result_t x;
		x = '0; x.action = a; x.prio = p; x.srv = s;
		return x;
	endfunction

	// next queue and server state and results of one event step; the enqueue of qp emits from slot n
	always_comb begin
		for (int i = 0; i < P; i++) begin
			queued_d[i] = queued_q[i]; arr_inc[i] = 1'b0; ref_inc[i] = 1'b0;
		end
		for (int i = 0; i < S; i++) srvp_d[i] = srvp_q[i];
		for (int i = 0; i < 4; i++) r[i] = '0;
		n = 3'd0; found = 1'b0; fs = '0; evp = '0; qp = '0; qhit = 1'b0; later = 1'b0;
		pidx = PIW'(prio_q - 4'd1);
		eidx = '0; qidx = '0;
		pok = (prio_q >= 4'd1) && (prio_q <= 4'(P));
		total = '0;
		for (int i = 0; i < P; i++) total = total + 9'(queued_q[i]);
		case (op_q)
			ppss_pkg::OP_ARRIVE: begin
				if (!pok) begin
					r[0] = mk(ppss_pkg::ACT_IDLE, 4'd0, 3'd0); n = 3'd1;
				end else begin
					arr_inc[pidx] = 1'b1;
					for (int i = S - 1; i >= 0; i--)
						if (srvp_q[i] == 4'd0) begin found = 1'b1; fs = 3'(i); end
					if (found) begin
						srvp_d[fs[SIW-1:0]] = prio_q;
						r[0] = mk(ppss_pkg::ACT_START, prio_q, fs); n = 3'd1;
						qp = '0;
					end else begin
						qp = prio_q;
						if (queued_q[0] >= thresh_q) begin
							for (int l = 1; l <= P; l++)
								if (4'(l) > prio_q)
									for (int i = S - 1; i >= 0; i--)
										if (srvp_q[i] == 4'(l)) begin
											found = 1'b1; fs = 3'(i); evp = 4'(l);
										end
							// last match wins: lowest priority, then lowest index
						end
						if (found) begin
							srvp_d[fs[SIW-1:0]] = prio_q;
							r[0] = mk(ppss_pkg::ACT_PREEMPT, evp, fs);
							r[1] = mk(ppss_pkg::ACT_START, prio_q, fs);
							n = 3'd2; qp = evp;
						end
					end
				end
			end
			ppss_pkg::OP_FINISH: begin
				if ({1'b0, srv_q} >= 4'(S) || srvp_q[srv_q[SIW-1:0]] == 4'd0) begin
					r[0] = mk(ppss_pkg::ACT_IDLE, 4'd0, srv_q); n = 3'd1;
				end else begin
					srvp_d[srv_q[SIW-1:0]] = 4'd0;
					for (int k = P; k >= 1; k--)
						if (queued_q[k-1] != 6'd0) begin qhit = 1'b1; evp = 4'(k); end
					if (qhit) begin
						eidx = PIW'(evp - 4'd1);
						queued_d[eidx] = queued_q[eidx] - 6'd1;
						srvp_d[srv_q[SIW-1:0]] = evp;
						r[0] = mk(ppss_pkg::ACT_START, evp, srv_q);
					end else r[0] = mk(ppss_pkg::ACT_IDLE, 4'd0, srv_q);
					n = 3'd1;
				end
			end
			ppss_pkg::OP_CHECK: begin
				if (chk_ok_q && srvp_q[ci_q[SIW-1:0]] > 4'd1 && queued_q[0] != 6'd0) begin
					evp = srvp_q[ci_q[SIW-1:0]];
					queued_d[0] = queued_q[0] - 6'd1;
					srvp_d[ci_q[SIW-1:0]] = 4'd1;
					r[0] = mk(ppss_pkg::ACT_PREEMPT, evp, ci_q);
					r[1] = mk(ppss_pkg::ACT_START, 4'd1, ci_q);
					n = 3'd2; qp = evp;
					total = total - 9'd1;
				end
			end
			default: begin
				if (pok) begin
					r[0] = mk(ppss_pkg::ACT_COUNT, prio_q, 3'd0);
					r[0].arr = arr_q[pidx];
					r[0].refc = ref_q[pidx];
				end else r[0] = mk(ppss_pkg::ACT_COUNT, prio_q, 3'd0);
				n = 3'd1;
			end
		endcase
		// shared enqueue of qp
		if (qp != 4'd0) begin
			qidx = PIW'(qp - 4'd1);
			if (total < 9'(qlimit_q)) begin
				queued_d[qidx] = queued_d[qidx] + 6'd1;
				r[n[1:0]] = mk(ppss_pkg::ACT_ENQ, qp, 3'd0);
				n = n + 3'd1;
			end else begin
				qhit = 1'b0; evp = '0;
				for (int l = 1; l <= P; l++)
					if (4'(l) > qp && queued_q[l-1] != 6'd0) begin qhit = 1'b1; evp = 4'(l); end
				if (qhit) begin
					eidx = PIW'(evp - 4'd1);
					queued_d[eidx] = queued_d[eidx] - 6'd1;
					ref_inc[eidx] = 1'b1;
					queued_d[qidx] = queued_d[qidx] + 6'd1;
					r[n[1:0]] = mk(ppss_pkg::ACT_PUSH, evp, 3'd0);
					r[2'(n + 3'd1)] = mk(ppss_pkg::ACT_ENQ, qp, 3'd0);
					n = n + 3'd2;
				end else begin
					ref_inc[qidx] = 1'b1;
					r[n[1:0]] = mk(ppss_pkg::ACT_REFUSE, qp, 3'd0);
					n = n + 3'd1;
				end
			end
		end
		// a later server still gets preempted in this tick only if it is busy
		// below the top priority and top-priority requests remain queued
		for (int j = 0; j < S; j++)
			if (3'(j) > ci_q && srvp_q[j] > 4'd1) later = 1'b1;
		later = later && chk_ok_q && (queued_d[0] != 6'd0);
	end

	// preemption victim search above keeps the lowest matching priority (largest number) and
	// within it the lowest index, matching the scan order

	always_comb begin
		stat.op = op_q;
		stat.nres = n;
		stat.chk_done = (ci_q >= 3'(S - 1)) || !later;
	end

	always_ff @(posedge clk) begin
		if (cmd.step) for (int i = 0; i < 4; i++) res[i] <= r[i];
	end
endmodule

// ===== rtl/core/ppss_ctrl.sv =====
// ppss_ctrl: sequencer for input acceptance, event steps and result delivery
// depends on ppss_pkg
`timescale 1ns / 1ps
module ppss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ppss_pkg::stat_t    stat,
	input  ppss_pkg::result_t  res [4],
	output ppss_pkg::result_t  out_data,
	output ppss_pkg::cmd_t     cmd
);
	ppss_pkg::state_t state_q, state_d;
	logic [2:0] cnt_q, idx_q;
	logic       any_q, more_q;
	logic [2:0] n_s1;
	logic       chk_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ppss_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// n and check status registered with the step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_s1 <= '0; chk_s1 <= 1'b0;
		end else if (cmd.step) begin
			n_s1 <= stat.nres; chk_s1 <= stat.chk_done;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ppss_pkg::ST_IDLE: if (in_valid) state_d = ppss_pkg::ST_DECIDE;
			ppss_pkg::ST_DECIDE: state_d = ppss_pkg::ST_CHECK;
			ppss_pkg::ST_CHECK: begin
				if (n_s1 != 3'd0) state_d = ppss_pkg::ST_EMIT;
				else if (stat.op != ppss_pkg::OP_CHECK || chk_s1) begin
					state_d = any_q ? ppss_pkg::ST_IDLE : ppss_pkg::ST_EMIT;
				end else state_d = ppss_pkg::ST_DECIDE;
			end
			ppss_pkg::ST_EMIT: if (out_ready && idx_q + 3'd1 >= cnt_q) begin
				state_d = more_q ? ppss_pkg::ST_DECIDE : ppss_pkg::ST_IDLE;
			end
			default: state_d = ppss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; idx_q <= '0; any_q <= 1'b0; more_q <= 1'b0;
		end else begin
			case (state_q)
				ppss_pkg::ST_IDLE: any_q <= 1'b0;
				ppss_pkg::ST_CHECK: begin
					idx_q <= '0;
					if (n_s1 != 3'd0) begin
						cnt_q <= n_s1; any_q <= 1'b1;
						more_q <= stat.op == ppss_pkg::OP_CHECK && !chk_s1;
					end else if (!any_q && (stat.op != ppss_pkg::OP_CHECK || chk_s1)) begin
						cnt_q <= 3'd0; more_q <= 1'b0;
					end
				end
				ppss_pkg::ST_EMIT: if (out_ready) idx_q <= idx_q + 3'd1;
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		out_data = '0;
		case (state_q)
			ppss_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid; cmd.chk_init = in_valid;
			end
			ppss_pkg::ST_DECIDE: cmd.step = 1'b1;
			ppss_pkg::ST_CHECK: cmd.chk_next = (n_s1 == 3'd0) && !chk_s1;
			ppss_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (cnt_q == 3'd0) begin
					out_data = '0;
					out_data.action = ppss_pkg::ACT_IDLE;
					out_data.last = 1'b1;
				end else begin
					out_data = res[idx_q[1:0]];
					out_data.last = (idx_q + 3'd1 >= cnt_q) && !more_q;
				end
				cmd.chk_next = out_ready && (idx_q + 3'd1 >= cnt_q) && more_q;
			end
			default: ;
		endcase
	end
endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking bench for the priority push-out server scheduler
// depends on ppss_pkg, ppss_if and priority_pushout_server_scheduler_unit
// in-bench scheduler predictor checks every result transfer in order
`timescale 1ns / 1ps
module testbench;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_idx;
	logic [5:0]  cfg_data;

	ppss_if #(.payload_t(ppss_pkg::in_item_t))  in_ch ();
	ppss_if #(.payload_t(ppss_pkg::out_item_t)) out_ch ();

	priority_pushout_server_scheduler_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// scheduler state mirrored by the predictor
	int unsigned sched_qlimit;
	int unsigned sched_thresh;
	int unsigned queued[1:8];
	int unsigned busy_prio[0:7];
	logic [31:0] arrivals[1:8];
	logic [31:0] refusals[1:8];

	ppss_pkg::in_item_t  pending_events[$];
	ppss_pkg::out_item_t expected_results[$];

	int errors;
	int events_sent;
	int results_seen;
	int cycles;
	bit event_taken;
	bit long_hold_req;
	bit long_hold_done;

	task automatic report(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	task automatic add_result(input logic [2:0] act, input int unsigned p, input int unsigned s,
			input logic [31:0] a = 0, input logic [31:0] r = 0);
		ppss_pkg::out_item_t res;
		res.action          = act;
		res.action_priority = p[ppss_pkg::PW-1:0];
		res.action_server   = s[ppss_pkg::SW-1:0];
		res.arrival_count   = a;
		res.refusal_count   = r;
		res.last            = 1'b0;
		expected_results.insert(expected_results.size(), res);
	endtask

	function automatic logic [31:0] sat_inc(input logic [31:0] c);
		return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

	// queue a request, pushing out a lower priority or refusing when full
	task automatic queue_request(input int unsigned p);
		int unsigned total;
		total = 0;
		for (int k = 1; k <= ppss_pkg::PRIORITIES; k++) total += queued[k];
		if (total < sched_qlimit) begin
			queued[p]++;
			add_result(ppss_pkg::ACT_ENQ, p, 0);
			return;
		end
		for (int lo = ppss_pkg::PRIORITIES; lo > p; lo--) begin
			if (queued[lo] > 0) begin
				queued[lo]--;
				refusals[lo] = sat_inc(refusals[lo]);
				queued[p]++;
				add_result(ppss_pkg::ACT_PUSH, lo, 0);
				add_result(ppss_pkg::ACT_ENQ, p, 0);
				return;
			end
		end
		refusals[p] = sat_inc(refusals[p]);
		add_result(ppss_pkg::ACT_REFUSE, p, 0);
	endtask

	task automatic place_arrival(input int unsigned p);
		for (int i = 0; i < ppss_pkg::SERVERS; i++) begin
			if (busy_prio[i] == 0) begin
				busy_prio[i] = p;
				add_result(ppss_pkg::ACT_START, p, i);
				return;
			end
		end
		if (queued[1] >= sched_thresh) begin
			for (int lo = ppss_pkg::PRIORITIES; lo > p; lo--) begin
				for (int i = 0; i < ppss_pkg::SERVERS; i++) begin
					if (busy_prio[i] == lo) begin
						busy_prio[i] = p;
						add_result(ppss_pkg::ACT_PREEMPT, lo, i);
						add_result(ppss_pkg::ACT_START, p, i);
						queue_request(lo);
						return;
					end
				end
			end
		end
		queue_request(p);
	endtask

	task automatic finish_service(input int unsigned s);
		if (s >= ppss_pkg::SERVERS || busy_prio[s] == 0) begin
			add_result(ppss_pkg::ACT_IDLE, 0, s);
			return;
		end
		busy_prio[s] = 0;
		for (int k = 1; k <= ppss_pkg::PRIORITIES; k++) begin
			if (queued[k] > 0) begin
				queued[k]--;
				busy_prio[s] = k;
				add_result(ppss_pkg::ACT_START, k, s);
				return;
			end
		end
		add_result(ppss_pkg::ACT_IDLE, 0, s);
	endtask

	task automatic preempt_sweep();
		int unsigned evicted;
		int n0;
		n0 = expected_results.size();
		if (queued[1] >= sched_thresh) begin
			for (int i = 0; i < ppss_pkg::SERVERS; i++) begin
				if (busy_prio[i] > 1 && queued[1] > 0) begin
					evicted = busy_prio[i];
					queued[1]--;
					busy_prio[i] = 1;
					add_result(ppss_pkg::ACT_PREEMPT, evicted, i);
					add_result(ppss_pkg::ACT_START, 1, i);
					queue_request(evicted);
				end
			end
		end
		if (expected_results.size() == n0) add_result(ppss_pkg::ACT_IDLE, 0, 0);
	endtask

	// work out every result of one accepted event
	task automatic schedule_event(input ppss_pkg::in_item_t ev);
		bit pok;
		int unsigned p;
		p = ev.priority_req;
		pok = (p >= 1 && p <= ppss_pkg::PRIORITIES);
		case (ev.opcode)
			ppss_pkg::OP_ARRIVE: begin
				if (pok) begin
					arrivals[p] = sat_inc(arrivals[p]);
					place_arrival(p);
				end else begin
					add_result(ppss_pkg::ACT_IDLE, 0, 0);
				end
			end
			ppss_pkg::OP_FINISH: finish_service(ev.server);
			ppss_pkg::OP_CHECK:  preempt_sweep();
			default: begin
				if (pok) add_result(ppss_pkg::ACT_COUNT, p, 0, arrivals[p], refusals[p]);
				else     add_result(ppss_pkg::ACT_COUNT, p, 0);
			end
		endcase
		expected_results[expected_results.size()-1].last = 1'b1;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("timeout with %0d results outstanding", expected_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// sampling side: predict on every event transfer, check every result transfer
	always @(posedge clk) begin
		ppss_pkg::out_item_t exp_r;
		ppss_pkg::out_item_t got;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			schedule_event(in_ch.data);
			events_sent++;
			event_taken = 1'b1;
			if (events_sent == 150 && !long_hold_done) long_hold_req = 1'b1;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			results_seen++;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result act=%0d prio=%0d srv=%0d",
					got.action, got.action_priority, got.action_server));
			end else begin
				exp_r = expected_results.pop_front();
				if (got.action !== exp_r.action)
					report($sformatf("action %0d, want %0d", got.action, exp_r.action));
				if (got.action_priority !== exp_r.action_priority)
					report($sformatf("priority %0d, want %0d",
						got.action_priority, exp_r.action_priority));
				if (got.action_server !== exp_r.action_server)
					report($sformatf("server %0d, want %0d",
						got.action_server, exp_r.action_server));
				if (got.arrival_count !== exp_r.arrival_count)
					report($sformatf("arrivals %0d, want %0d",
						got.arrival_count, exp_r.arrival_count));
				if (got.refusal_count !== exp_r.refusal_count)
					report($sformatf("refusals %0d, want %0d",
						got.refusal_count, exp_r.refusal_count));
				if (got.last !== exp_r.last)
					report($sformatf("last %0b, want %0b", got.last, exp_r.last));
			end
		end
	end

	// event driver: pops pending events, random gap before each, bursts without gaps
	int  send_gap;
	bit  send_burst;
	always @(negedge clk) begin
		logic nv;
		nv = in_ch.valid;
		if (event_taken) begin
			nv = 1'b0;
			event_taken = 1'b0;
			if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
			send_gap = send_burst ? 0 : $urandom_range(0, 16);
		end
		if (!nv && arst_n) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_events.size() > 0) begin
				in_ch.data <= pending_events.pop_front();
				nv = 1'b1;
			end
		end
		in_ch.valid <= nv;
	end

	// result receiver: random stall per result, one long hold-off to back up the block
	int  take_stall;
	int  long_hold;
	bit  take_burst;
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			long_hold_done = 1'b1;
			long_hold = 400;
		end
		if (long_hold > 0) begin
			long_hold--;
			out_ch.ready <= 1'b0;
		end else if (take_stall > 0) begin
			take_stall--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if ($urandom_range(0, 60) == 0) take_burst = ~take_burst;
			take_stall = take_burst ? 0 : $urandom_range(0, 16);
		end
	end

	task automatic write_reg(input logic [0:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value[5:0];
		@(negedge clk);
		cfg_we   <= 1'b0;
		if (idx == ppss_pkg::REG_QLIMIT) sched_qlimit = value[5:0];
		else                             sched_thresh = value[5:0];
	endtask

	// sender pause: wait for the block to drain fully, then let it settle
	task automatic drain();
		while (!(pending_events.size() == 0 && !in_ch.valid && !event_taken
				&& expected_results.size() == 0))
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic queue_event(input logic [1:0] op, input int unsigned p, input int unsigned s);
		ppss_pkg::in_item_t ev;
		ev.opcode       = op;
		ev.priority_req = p[ppss_pkg::PW-1:0];
		ev.server       = s[ppss_pkg::SW-1:0];
		pending_events.insert(pending_events.size(), ev);
	endtask

	// mostly arrivals and completions of real servers, some reads, checks and odd fields
	task automatic queue_random(input int count);
		int unsigned r;
		int unsigned p;
		int unsigned s;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
				: $urandom_range(1, ppss_pkg::PRIORITIES);
			s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
				: $urandom_range(0, ppss_pkg::SERVERS-1);
			if (r < 45)      queue_event(ppss_pkg::OP_ARRIVE, p, s);
			else if (r < 80) queue_event(ppss_pkg::OP_FINISH, p, s);
			else if (r < 90) queue_event(ppss_pkg::OP_CHECK, p, s);
			else             queue_event(ppss_pkg::OP_READ, p, s);
		end
	endtask

	initial begin
		int unsigned ql[6];
		int unsigned th[6];
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		sched_qlimit = 6;
		sched_thresh = 2;
		for (int k = 1; k <= 8; k++) begin
			queued[k] = 0;
			arrivals[k] = 0;
			refusals[k] = 0;
		end
		for (int i = 0; i < 8; i++) busy_prio[i] = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fill servers, fill queue, push-out, refusal, preemption
		for (int i = 0; i < 4; i++) queue_event(ppss_pkg::OP_ARRIVE, 2, 0);
		for (int i = 0; i < 6; i++) queue_event(ppss_pkg::OP_ARRIVE, 2, 0);
		queue_event(ppss_pkg::OP_ARRIVE, 1, 0);   // queue full, pushes out a low priority
		queue_event(ppss_pkg::OP_ARRIVE, 2, 0);   // nothing lower to push, refused
		queue_event(ppss_pkg::OP_ARRIVE, 1, 0);
		queue_event(ppss_pkg::OP_ARRIVE, 1, 0);   // top queue at threshold, preempts
		queue_event(ppss_pkg::OP_ARRIVE, 0, 0);   // out-of-range priorities ignored
		queue_event(ppss_pkg::OP_ARRIVE, 15, 0);
		queue_event(ppss_pkg::OP_FINISH, 0, 0);   // refill from queue
		queue_event(ppss_pkg::OP_FINISH, 0, 7);   // nonexistent server
		queue_event(ppss_pkg::OP_CHECK, 0, 0);
		queue_event(ppss_pkg::OP_READ, 0, 0);
		queue_event(ppss_pkg::OP_READ, 1, 0);
		queue_event(ppss_pkg::OP_READ, 2, 0);
		queue_event(ppss_pkg::OP_READ, 15, 0);
		queue_event(ppss_pkg::OP_FINISH, 0, 3);
		drain();

		// completions until everything is idle, then threshold 0 for check sweeps
		for (int i = 0; i < 12; i++) queue_event(ppss_pkg::OP_FINISH, 0, i % ppss_pkg::SERVERS);
		queue_event(ppss_pkg::OP_CHECK, 0, 0);    // empty queue, nothing to preempt
		drain();
		write_reg(ppss_pkg::REG_THRESH, 0);
		for (int i = 0; i < 4; i++) queue_event(ppss_pkg::OP_ARRIVE, 2, 0);
		for (int i = 0; i < 3; i++) queue_event(ppss_pkg::OP_ARRIVE, 1, 0);
		queue_event(ppss_pkg::OP_CHECK, 0, 0);
		drain();

		// random phases across register settings, extremes included
		ql = '{0, 63, 1, 3, 6, 0};
		th = '{0, 63, 0, 1, 2, 0};
		ql[5] = $urandom_range(0, 63);
		th[5] = $urandom_range(0, 63);
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(ppss_pkg::REG_QLIMIT, ql[ph]);
			write_reg(ppss_pkg::REG_THRESH, th[ph]);
			queue_random(62);
			drain();
		end

		repeat (30) @(posedge clk);
		$display("covered %0d events and %0d results over six register settings",
			events_sent, results_seen);
		$display("including push-out, refusal, preemption sweeps and a long output stall");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_results.size());
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/ppss_pkg.sv
rtl/core/ppss_if.sv
rtl/core/ppss_datapath.sv
rtl/core/ppss_ctrl.sv
rtl/core/priority_pushout_server_scheduler_unit.sv
sim/testbench.sv
